/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every clock edge out of reset
`define CAF_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("autofocus assertion failed");
// consequent holds in the cycle after the antecedent
`define CAF_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("autofocus assertion failed");
`else
`define CAF_ASSERT(name, clk, rst, prop)
`define CAF_ASSERT_NEXT(name, clk, rst, pre, post)
`endif
`endif

/* hw/rtl/caf_pkg.sv */
// ----------------------------------------------------------------------------
// caf_pkg
// shared constants, codes and types of the contrast autofocus controller
// ----------------------------------------------------------------------------
package caf_pkg;

   // sweep geometry
   localparam int COARSE_POINTS  = 14;
   localparam int FINE_DIVISOR   = 32;
   localparam int FINE_HALF_SPAN = 2;
   localparam int POS_BITS       = 10;

   localparam int COARSE_LEN = (COARSE_POINTS < 16) ? COARSE_POINTS : 16;
   localparam int FINE_LEN   = (2 * FINE_HALF_SPAN + 1 < 16) ? 2 * FINE_HALF_SPAN + 1 : 16;
   localparam int COARSE_DIV = COARSE_POINTS - 1;
   localparam int DIV_MAX    = (FINE_DIVISOR > COARSE_DIV) ? FINE_DIVISOR : COARSE_DIV;
   localparam int DIV_W      = $clog2(DIV_MAX + 1);
   localparam int ACC_W      = POS_BITS + 4;
   localparam int K_W        = $clog2(FINE_HALF_SPAN + 1);
   localparam int SCORE_W    = 24;
   localparam int CSR_DATA_W = 24;

   // reciprocal multipliers for the point spacing divides, exact over the span
   localparam int RECIP_SHIFT  = POS_BITS + DIV_W;
   localparam int REC_W        = RECIP_SHIFT;
   localparam int PROD_W       = POS_BITS + REC_W;
   localparam int RECIP_COARSE = ((1 << RECIP_SHIFT) + COARSE_DIV - 1) / COARSE_DIV;
   localparam int RECIP_FINE   = ((1 << RECIP_SHIFT) + FINE_DIVISOR - 1) / FINE_DIVISOR;

   // item kinds
   localparam logic [1:0] FUNC_FRAME = 2'd0;
   localparam logic [1:0] FUNC_MODE  = 2'd1;
   localparam logic [1:0] FUNC_TRIG  = 2'd2;

   // af modes
   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_AUTO  = 2'd1;
   localparam logic [1:0] MODE_VIDEO = 2'd3;

   // trigger kinds
   localparam logic [1:0] TRIG_START  = 2'd1;
   localparam logic [1:0] TRIG_CANCEL = 2'd2;

   // reported af states
   localparam logic [2:0] AF_INACTIVE       = 3'd0;
   localparam logic [2:0] AF_PASSIVE_SCAN   = 3'd1;
   localparam logic [2:0] AF_PASSIVE_FOCUS  = 3'd2;
   localparam logic [2:0] AF_PASSIVE_UNFOC  = 3'd3;
   localparam logic [2:0] AF_ACTIVE_SCAN    = 3'd4;
   localparam logic [2:0] AF_FOCUSED_LOCK   = 3'd5;
   localparam logic [2:0] AF_UNFOCUSED_LOCK = 3'd6;

   // register indexes
   localparam logic [2:0] CSR_LENS_MIN      = 3'd0;
   localparam logic [2:0] CSR_LENS_MAX      = 3'd1;
   localparam logic [2:0] CSR_SETTLE_FRAMES = 3'd2;
   localparam logic [2:0] CSR_MAX_MOVES     = 3'd3;
   localparam logic [2:0] CSR_MIN_SCORE     = 3'd4;
   localparam logic [2:0] CSR_RESCAN_REL    = 3'd5;
   localparam logic [2:0] CSR_RESCAN_ABS    = 3'd6;
   localparam logic [2:0] CSR_RESCAN_FRAMES = 3'd7;

   // divider command and result
   typedef struct packed {
      logic                start;
      logic                fine;
      logic [POS_BITS-1:0] dividend;
   } caf_div_cmd_type;

   typedef struct packed {
      logic                done;
      logic [POS_BITS-1:0] quot;
      logic [DIV_W-1:0]    rem;
   } caf_div_res_type;

endpackage

/* hw/rtl/caf_ifs.sv */
// ----------------------------------------------------------------------------
// caf channel interfaces
// request, response and register write channels
// ----------------------------------------------------------------------------
interface caf_req_if import caf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          func;
   logic [SCORE_W-1:0]  frame_score;
   logic                scene_stable;
   logic                hold_enable;
   logic [POS_BITS-1:0] hold_position;
   logic [1:0]          af_mode;
   logic [1:0]          trigger_kind;
   logic                lens_ready;
   logic                move_accepted;

   modport source (output valid, func, frame_score, scene_stable, hold_enable,
                   hold_position, af_mode, trigger_kind, lens_ready, move_accepted,
                   input ready);
   modport sink (input valid, func, frame_score, scene_stable, hold_enable,
                 hold_position, af_mode, trigger_kind, lens_ready, move_accepted,
                 output ready);
endinterface

interface caf_rsp_if import caf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [2:0]          af_state;
   logic                lens_moving;
   logic [POS_BITS-1:0] lens_position;
   logic                move_issued;
   logic [POS_BITS-1:0] best_position;

   modport source (output valid, af_state, lens_moving, lens_position, move_issued,
                   best_position, input ready);
   modport sink (input valid, af_state, lens_moving, lens_position, move_issued,
                 best_position, output ready);
endinterface

interface caf_csr_if import caf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [2:0]            addr;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

/* hw/rtl/caf_ram.sv */
// ----------------------------------------------------------------------------
// caf_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module caf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/caf_div.sv */
// ----------------------------------------------------------------------------
// caf_div
// reciprocal divider by a fixed coarse or fine sweep divisor; done follows the latch, multiply and remainder registers
// ----------------------------------------------------------------------------
module caf_div import caf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  caf_div_cmd_type cmd,
   output caf_div_res_type res
);

   logic                       busy_ff, busy_in;
   logic                       mul_ff, mul_in;
   logic                       done_ff, done_in;
   logic                       fine_ff, fine_in;
   logic [POS_BITS-1:0]        dvd_ff, dvd_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [POS_BITS-1:0]        quo_ff, quo_in;
   logic [DIV_W-1:0]           rem_ff, rem_in;
   logic [REC_W-1:0]           recip;
   logic [DIV_W-1:0]           divisor;
   logic [POS_BITS-1:0]        quo_c;
   logic [POS_BITS+DIV_W-1:0]  back;

   // divisor and its reciprocal
   assign recip   = fine_ff ? REC_W'(RECIP_FINE) : REC_W'(RECIP_COARSE);
   assign divisor = fine_ff ? DIV_W'(FINE_DIVISOR) : DIV_W'(COARSE_DIV);
   assign quo_c   = prod_ff[RECIP_SHIFT +: POS_BITS];
   assign back    = quo_c * divisor;

   // latch, multiply, then quotient and remainder
   always_comb begin
      busy_in = 1'b0;
      mul_in  = 1'b0;
      done_in = 1'b0;
      fine_in = fine_ff;
      dvd_in  = dvd_ff;
      prod_in = prod_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         fine_in = cmd.fine;
         dvd_in  = cmd.dividend;
      end
      if (busy_ff) begin
         prod_in = dvd_ff * recip;
         mul_in  = 1'b1;
      end
      if (mul_ff) begin
         quo_in  = quo_c;
         rem_in  = DIV_W'({{DIV_W{1'b0}}, dvd_ff} - back);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         mul_ff  <= mul_in;
         done_ff <= done_in;
      end
      fine_ff <= fine_in;
      dvd_ff  <= dvd_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign res.done = done_ff;
   assign res.quot = quo_ff;
   assign res.rem  = rem_ff;

endmodule

/* hw/rtl/caf_ctrl.sv */
// ----------------------------------------------------------------------------
// caf_ctrl
// autofocus sequencer: item decode, hold, rescan test, sweep point fill, point search, lock
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module caf_ctrl import caf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   caf_req_if.sink              req_bus,
   caf_rsp_if.source            rsp_bus,
   caf_csr_if.sink              csr_bus,
   output caf_div_cmd_type      div_cmd,
   input  caf_div_res_type      div_res,
   output logic                 ram_we,
   output logic [3:0]           ram_waddr,
   output logic [POS_BITS-1:0]  ram_wdata,
   output logic [3:0]           ram_raddr,
   input  logic [POS_BITS-1:0]  ram_rdata
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_EXEC, ST_FRAME2, ST_RS_MUL, ST_RS_CMP,
      ST_SS_DIV, ST_SS_WAIT, ST_SS_FILL,
      ST_FB_DIV, ST_FB_WAIT, ST_FB_BACK, ST_FB_FILL,
      ST_SRCH_RD, ST_SRCH_CHK, ST_FIN, ST_DONE
   } state_type;

   // configuration
   logic [POS_BITS-1:0] lens_min_ff, lens_max_ff;
   logic [3:0]          settle_cfg_ff, rescan_frames_ff;
   logic [5:0]          max_moves_ff;
   logic [SCORE_W-1:0]  min_score_ff, rescan_abs_ff;
   logic [7:0]          rescan_rel_ff;

   // sequencer and latched item
   state_type           state_ff, state_in;
   logic                ret_frame2_ff, ret_frame2_in;
   logic [1:0]          func_ff, func_in;
   logic [SCORE_W-1:0]  score_ff, score_in;
   logic                stable_ff, stable_in;
   logic                hold_en_ff, hold_en_in;
   logic [POS_BITS-1:0] hold_pos_ff, hold_pos_in;
   logic [1:0]          mode_req_ff, mode_req_in;
   logic [1:0]          trig_kind_ff, trig_kind_in;
   logic                ready_now_ff, ready_now_in;
   logic                accept_now_ff, accept_now_in;
   logic                moved_now_ff, moved_now_in;

   // focus state
   logic [1:0]          mode_ff, mode_in;
   logic                trig_ff, trig_in, scan_ff, scan_in, conv_ff, conv_in;
   logic                fine_ff, fine_in, hold_ff, hold_in, moved_ff, moved_in;
   logic [3:0]          settle_ff, settle_in;
   logic [5:0]          move_cnt_ff, move_cnt_in;
   logic [3:0]          change_cnt_ff, change_cnt_in;
   logic [SCORE_W-1:0]  best_score_ff, best_score_in;
   logic [POS_BITS-1:0] best_pos_ff, best_pos_in;
   logic                ref_inval_ff, ref_inval_in;
   logic [SCORE_W-1:0]  ref_score_ff, ref_score_in;
   logic [POS_BITS-1:0] lens_pos_ff, lens_pos_in;
   logic [4:0]          sweep_idx_ff, sweep_idx_in;
   logic                moving_latch_ff, moving_latch_in;

   // scratch of the fill and rescan steps
   logic [4:0]              fill_ff, fill_in;
   logic [POS_BITS-1:0]     q_acc_ff, q_acc_in;
   logic [DIV_W-1:0]        r_acc_ff, r_acc_in;
   logic [POS_BITS-1:0]     step_ff, step_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [K_W-1:0]          k_ff, k_in;
   logic [SCORE_W-1:0]      delta_ff, delta_in;
   logic [31:0]             prod_ff, prod_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_state_ff, rsp_state_in;
   logic                rsp_moving_ff, rsp_moving_in;
   logic [POS_BITS-1:0] rsp_pos_ff, rsp_pos_in;
   logic                rsp_issued_ff, rsp_issued_in;
   logic [POS_BITS-1:0] rsp_best_ff, rsp_best_in;

   // helpers
   logic                req_fire, move_ok, hold_hit, start_req, start_ret;
   logic [POS_BITS-1:0] range_hi, span;
   logic [DIV_W:0]      r_sum;
   logic [4:0]          sweep_len;
   logic [3:0]          cc_next;
   logic [2:0]          af_state_c;
   logic [POS_BITS-1:0] fine_pt;
   logic signed [ACC_W-1:0] lo_s, hi_s;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign move_ok   = ready_now_ff && accept_now_ff;
   assign range_hi  = (lens_max_ff > lens_min_ff) ? lens_max_ff : lens_min_ff;
   assign span      = range_hi - lens_min_ff;
   assign hold_hit  = hold_en_ff && (hold_pos_ff >= lens_min_ff) && (hold_pos_ff <= range_hi);
   assign r_sum     = {1'b0, r_acc_ff} + {1'b0, div_res.rem};
   assign sweep_len = fine_ff ? 5'(FINE_LEN) : 5'(COARSE_LEN);
   assign cc_next   = (change_cnt_ff == 4'd15) ? 4'd15 : change_cnt_ff + 4'd1;
   assign lo_s      = $signed({{(ACC_W-POS_BITS){1'b0}}, lens_min_ff});
   assign hi_s      = $signed({{(ACC_W-POS_BITS){1'b0}}, range_hi});
   assign fine_pt   = (acc_ff < lo_s) ? lens_min_ff :
                      (acc_ff > hi_s) ? range_hi : acc_ff[POS_BITS-1:0];

   // reported af state from the settled flags
   always_comb begin
      if (!ready_now_ff || mode_ff == MODE_OFF || hold_ff) begin
         af_state_c = AF_INACTIVE;
      end else if (mode_ff == MODE_AUTO) begin
         if (!trig_ff) begin
            af_state_c = AF_INACTIVE;
         end else if (scan_ff) begin
            af_state_c = AF_ACTIVE_SCAN;
         end else begin
            af_state_c = conv_ff ? AF_FOCUSED_LOCK : AF_UNFOCUSED_LOCK;
         end
      end else if (scan_ff) begin
         af_state_c = AF_PASSIVE_SCAN;
      end else if (trig_ff) begin
         af_state_c = conv_ff ? AF_FOCUSED_LOCK : AF_UNFOCUSED_LOCK;
      end else begin
         af_state_c = conv_ff ? AF_PASSIVE_FOCUS : AF_PASSIVE_UNFOC;
      end
   end

   // register writes
   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         lens_min_ff      <= '0;
         lens_max_ff      <= '1;
         settle_cfg_ff    <= 4'd3;
         max_moves_ff     <= 6'd24;
         min_score_ff     <= 24'd160;
         rescan_rel_ff    <= 8'd77;
         rescan_abs_ff    <= 24'd80;
         rescan_frames_ff <= 4'd3;
      end else if (csr_bus.valid) begin
         case (csr_bus.addr)
            CSR_LENS_MIN:      lens_min_ff      <= csr_bus.data[POS_BITS-1:0];
            CSR_LENS_MAX:      lens_max_ff      <= csr_bus.data[POS_BITS-1:0];
            CSR_SETTLE_FRAMES: settle_cfg_ff    <= csr_bus.data[3:0];
            CSR_MAX_MOVES:     max_moves_ff     <= csr_bus.data[5:0];
            CSR_MIN_SCORE:     min_score_ff     <= csr_bus.data[SCORE_W-1:0];
            CSR_RESCAN_REL:    rescan_rel_ff    <= csr_bus.data[7:0];
            CSR_RESCAN_ABS:    rescan_abs_ff    <= csr_bus.data[SCORE_W-1:0];
            CSR_RESCAN_FRAMES: rescan_frames_ff <= csr_bus.data[3:0];
            default: ;
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;  ret_frame2_in = ret_frame2_ff;
      func_in = func_ff;  score_in = score_ff;  stable_in = stable_ff;
      hold_en_in = hold_en_ff;  hold_pos_in = hold_pos_ff;  mode_req_in = mode_req_ff;
      trig_kind_in = trig_kind_ff;  ready_now_in = ready_now_ff;
      accept_now_in = accept_now_ff;  moved_now_in = moved_now_ff;
      mode_in = mode_ff;  trig_in = trig_ff;  scan_in = scan_ff;  conv_in = conv_ff;
      fine_in = fine_ff;  hold_in = hold_ff;  moved_in = moved_ff;
      settle_in = settle_ff;  move_cnt_in = move_cnt_ff;  change_cnt_in = change_cnt_ff;
      best_score_in = best_score_ff;  best_pos_in = best_pos_ff;
      ref_inval_in = ref_inval_ff;  ref_score_in = ref_score_ff;
      lens_pos_in = lens_pos_ff;  sweep_idx_in = sweep_idx_ff;
      moving_latch_in = moving_latch_ff;
      fill_in = fill_ff;  q_acc_in = q_acc_ff;  r_acc_in = r_acc_ff;
      step_in = step_ff;  acc_in = acc_ff;  k_in = k_ff;
      delta_in = delta_ff;  prod_in = prod_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_state_in = rsp_state_ff;
      rsp_moving_in = rsp_moving_ff;  rsp_pos_in = rsp_pos_ff;
      rsp_issued_in = rsp_issued_ff;  rsp_best_in = rsp_best_ff;
      start_req = 1'b0;  start_ret = 1'b0;
      ram_we = 1'b0;  ram_waddr = fill_ff[3:0];  ram_wdata = '0;
      ram_raddr = sweep_idx_ff[3:0];
      div_cmd.start = 1'b0;  div_cmd.fine = 1'b0;  div_cmd.dividend = span;

      // response transfer
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in       = req_bus.func;
               score_in      = req_bus.frame_score;
               stable_in     = req_bus.scene_stable;
               hold_en_in    = req_bus.hold_enable;
               hold_pos_in   = req_bus.hold_position;
               mode_req_in   = req_bus.af_mode;
               trig_kind_in  = req_bus.trigger_kind;
               ready_now_in  = req_bus.lens_ready;
               accept_now_in = req_bus.move_accepted;
               moved_now_in  = 1'b0;
               state_in      = ST_EXEC;
            end
         end

         // decode the item
         ST_EXEC: begin
            state_in = ST_DONE;
            case (func_ff)
               FUNC_FRAME: begin
                  moving_latch_in = moved_ff;
                  moved_in = 1'b0;
                  if (!ready_now_ff) begin
                     state_in = ST_DONE;
                  end else if (hold_hit) begin
                     hold_in = 1'b1;
                     scan_in = 1'b0;
                     if (lens_pos_ff != hold_pos_ff) begin
                        if (move_ok) begin
                           lens_pos_in  = hold_pos_ff;
                           moved_now_in = 1'b1;
                           moved_in     = 1'b1;
                           settle_in    = settle_cfg_ff;
                        end
                     end else if (settle_ff != 4'd0) begin
                        settle_in = settle_ff - 4'd1;
                     end
                  end else if (hold_ff) begin
                     hold_in = 1'b0;
                     if (mode_ff[1]) begin
                        start_req = 1'b1;
                        start_ret = 1'b1;
                     end else begin
                        state_in = ST_FRAME2;
                     end
                  end else begin
                     state_in = ST_FRAME2;
                  end
               end
               FUNC_MODE: begin
                  if (mode_req_ff != mode_ff) begin
                     mode_in       = mode_req_ff;
                     trig_in       = 1'b0;
                     scan_in       = 1'b0;
                     conv_in       = 1'b0;
                     change_cnt_in = '0;
                     ref_inval_in  = 1'b1;
                     start_req     = mode_req_ff[1];
                  end
               end
               FUNC_TRIG: begin
                  if (mode_ff != MODE_OFF) begin
                     if (trig_kind_ff == TRIG_START) begin
                        trig_in = 1'b1;
                        if (mode_ff == MODE_AUTO) begin
                           start_req = 1'b1;
                        end else if (scan_ff && mode_ff == MODE_VIDEO) begin
                           state_in = ST_FIN;
                        end
                     end else if (trig_kind_ff == TRIG_CANCEL) begin
                        trig_in       = 1'b0;
                        change_cnt_in = '0;
                        if (mode_ff == MODE_AUTO) begin
                           scan_in = 1'b0;
                           conv_in = 1'b0;
                        end
                     end
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end

         // frame handling after hold
         ST_FRAME2: begin
            state_in = ST_DONE;
            if (mode_ff == MODE_OFF) begin
               state_in = ST_DONE;
            end else if (mode_ff == MODE_AUTO && !trig_ff) begin
               scan_in = 1'b0;
            end else if (!stable_ff) begin
               state_in = ST_DONE;
            end else if (!scan_ff) begin
               if (trig_ff) begin
                  state_in = ST_DONE;
               end else if (settle_ff != 4'd0) begin
                  settle_in = settle_ff - 4'd1;
               end else if (ref_inval_ff) begin
                  ref_score_in  = score_ff;
                  ref_inval_in  = 1'b0;
                  change_cnt_in = '0;
               end else begin
                  state_in = ST_RS_MUL;
               end
            end else if (settle_ff != 4'd0) begin
               settle_in = settle_ff - 4'd1;
            end else begin
               if (score_ff > best_score_ff) begin
                  best_score_in = score_ff;
                  best_pos_in   = lens_pos_ff;
               end
               state_in = ST_SRCH_RD;
            end
         end

         // rescan test: deviation and scaled reference
         ST_RS_MUL: begin
            delta_in = (score_ff > ref_score_ff) ? score_ff - ref_score_ff
                                                 : ref_score_ff - score_ff;
            prod_in  = ref_score_ff * rescan_rel_ff;
            state_in = ST_RS_CMP;
         end

         ST_RS_CMP: begin
            state_in = ST_DONE;
            if (({delta_ff, 8'd0} > prod_ff) && (delta_ff > rescan_abs_ff)) begin
               change_cnt_in = cc_next;
               if (cc_next >= rescan_frames_ff) begin
                  start_req = 1'b1;
               end
            end else begin
               change_cnt_in = '0;
            end
         end

         // coarse points: span split into near-equal parts, remainder spread over them
         ST_SS_DIV: begin
            div_cmd.start = 1'b1;
            q_acc_in = '0;
            r_acc_in = '0;
            fill_in  = '0;
            state_in = ST_SS_WAIT;
         end

         ST_SS_WAIT: begin
            if (div_res.done) begin
               state_in = ST_SS_FILL;
            end
         end

         ST_SS_FILL: begin
            ram_we    = 1'b1;
            ram_wdata = lens_min_ff + q_acc_ff;
            if (r_sum >= (DIV_W+1)'(COARSE_DIV)) begin
               r_acc_in = DIV_W'(r_sum - (DIV_W+1)'(COARSE_DIV));
               q_acc_in = q_acc_ff + div_res.quot + 1'b1;
            end else begin
               r_acc_in = r_sum[DIV_W-1:0];
               q_acc_in = q_acc_ff + div_res.quot;
            end
            fill_in = fill_ff + 5'd1;
            if (fill_ff == 5'(COARSE_LEN - 1)) begin
               state_in = ret_frame2_ff ? ST_FRAME2 : ST_DONE;
            end
         end

         // fine points around the best position
         ST_FB_DIV: begin
            div_cmd.start = 1'b1;
            div_cmd.fine  = 1'b1;
            state_in      = ST_FB_WAIT;
         end

         ST_FB_WAIT: begin
            if (div_res.done) begin
               step_in  = (div_res.quot == '0) ? POS_BITS'(1) : div_res.quot;
               acc_in   = $signed({{(ACC_W-POS_BITS){1'b0}}, best_pos_ff});
               k_in     = K_W'(FINE_HALF_SPAN);
               fill_in  = '0;
               state_in = ST_FB_BACK;
            end
         end

         ST_FB_BACK: begin
            if (k_ff != '0) begin
               acc_in = acc_ff - $signed({{(ACC_W-POS_BITS){1'b0}}, step_ff});
               k_in   = k_ff - 1'b1;
            end else begin
               state_in = ST_FB_FILL;
            end
         end

         ST_FB_FILL: begin
            ram_we    = 1'b1;
            ram_wdata = fine_pt;
            acc_in    = acc_ff + $signed({{(ACC_W-POS_BITS){1'b0}}, step_ff});
            fill_in   = fill_ff + 5'd1;
            if (fill_ff == 5'(FINE_LEN - 1)) begin
               sweep_idx_in = '0;
               fine_in      = 1'b1;
               state_in     = ST_SRCH_RD;
            end
         end

         // next sweep point that differs from the lens position
         ST_SRCH_RD: begin
            if (sweep_idx_ff < sweep_len) begin
               sweep_idx_in = sweep_idx_ff + 5'd1;
               state_in     = ST_SRCH_CHK;
            end else if (fine_ff) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_FB_DIV;
            end
         end

         ST_SRCH_CHK: begin
            if (ram_rdata != lens_pos_ff) begin
               if (move_cnt_ff >= max_moves_ff) begin
                  state_in = ST_FIN;
               end else begin
                  move_cnt_in = move_cnt_ff + 6'd1;
                  if (!move_ok) begin
                     state_in = ST_FIN;
                  end else begin
                     lens_pos_in  = ram_rdata;
                     moved_now_in = 1'b1;
                     moved_in     = 1'b1;
                     settle_in    = settle_cfg_ff;
                     state_in     = ST_DONE;
                  end
               end
            end else begin
               state_in = ST_SRCH_RD;
            end
         end

         // end of scan: return to best point
         ST_FIN: begin
            scan_in       = 1'b0;
            conv_in       = best_score_ff >= min_score_ff;
            change_cnt_in = '0;
            settle_in     = '0;
            if (lens_pos_ff != best_pos_ff && move_ok) begin
               lens_pos_in  = best_pos_ff;
               moved_now_in = 1'b1;
               moved_in     = 1'b1;
               settle_in    = settle_cfg_ff;
            end
            ref_inval_in = 1'b1;
            state_in     = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_state_in  = af_state_c;
               rsp_moving_in = moving_latch_ff;
               rsp_pos_in    = lens_pos_ff;
               rsp_issued_in = moved_now_ff;
               rsp_best_in   = best_pos_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // scan start
      if (start_req) begin
         ret_frame2_in = start_ret;
         if (ready_now_ff) begin
            scan_in       = 1'b1;
            conv_in       = 1'b0;
            fine_in       = 1'b0;
            move_cnt_in   = '0;
            best_score_in = '0;
            best_pos_in   = lens_pos_ff;
            change_cnt_in = '0;
            sweep_idx_in  = '0;
            settle_in     = settle_cfg_ff;
            state_in      = ST_SS_DIV;
         end else begin
            state_in = start_ret ? ST_FRAME2 : ST_DONE;
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         ret_frame2_ff   <= 1'b0;
         ready_now_ff    <= 1'b0;
         accept_now_ff   <= 1'b0;
         moved_now_ff    <= 1'b0;
         mode_ff         <= MODE_OFF;
         trig_ff         <= 1'b0;
         scan_ff         <= 1'b0;
         conv_ff         <= 1'b0;
         fine_ff         <= 1'b0;
         hold_ff         <= 1'b0;
         moved_ff        <= 1'b0;
         settle_ff       <= '0;
         move_cnt_ff     <= '0;
         change_cnt_ff   <= '0;
         best_score_ff   <= '0;
         best_pos_ff     <= '0;
         ref_inval_ff    <= 1'b1;
         lens_pos_ff     <= '0;
         sweep_idx_ff    <= '0;
         moving_latch_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         ret_frame2_ff   <= ret_frame2_in;
         ready_now_ff    <= ready_now_in;
         accept_now_ff   <= accept_now_in;
         moved_now_ff    <= moved_now_in;
         mode_ff         <= mode_in;
         trig_ff         <= trig_in;
         scan_ff         <= scan_in;
         conv_ff         <= conv_in;
         fine_ff         <= fine_in;
         hold_ff         <= hold_in;
         moved_ff        <= moved_in;
         settle_ff       <= settle_in;
         move_cnt_ff     <= move_cnt_in;
         change_cnt_ff   <= change_cnt_in;
         best_score_ff   <= best_score_in;
         best_pos_ff     <= best_pos_in;
         ref_inval_ff    <= ref_inval_in;
         lens_pos_ff     <= lens_pos_in;
         sweep_idx_ff    <= sweep_idx_in;
         moving_latch_ff <= moving_latch_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      func_ff       <= func_in;
      score_ff      <= score_in;
      stable_ff     <= stable_in;
      hold_en_ff    <= hold_en_in;
      hold_pos_ff   <= hold_pos_in;
      mode_req_ff   <= mode_req_in;
      trig_kind_ff  <= trig_kind_in;
      ref_score_ff  <= ref_score_in;
      fill_ff       <= fill_in;
      q_acc_ff      <= q_acc_in;
      r_acc_ff      <= r_acc_in;
      step_ff       <= step_in;
      acc_ff        <= acc_in;
      k_ff          <= k_in;
      delta_ff      <= delta_in;
      prod_ff       <= prod_in;
      rsp_state_ff  <= rsp_state_in;
      rsp_moving_ff <= rsp_moving_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_issued_ff <= rsp_issued_in;
      rsp_best_ff   <= rsp_best_in;
   end

   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.af_state      = rsp_state_ff;
   assign rsp_bus.lens_moving   = rsp_moving_ff;
   assign rsp_bus.lens_position = rsp_pos_ff;
   assign rsp_bus.move_issued   = rsp_issued_ff;
   assign rsp_bus.best_position = rsp_best_ff;

   // checks
   `CAF_ASSERT(a_sweep_idx_bound, clock, reset, sweep_idx_ff <= 5'd16)
   `CAF_ASSERT(a_move_needs_lens, clock, reset, moved_now_ff |-> (ready_now_ff && accept_now_ff))
   `CAF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, state_ff != ST_IDLE)

endmodule

/* hw/rtl/contrast_af_sweep_controller_top.sv */
// ----------------------------------------------------------------------------
// contrast_af_sweep_controller_top
// contrast autofocus sweep controller: sequencer, divider and sweep point ram
// ----------------------------------------------------------------------------
//  channel   dir  contents
//  req_bus   in   frame score, mode change or trigger, lens status
//  rsp_bus   out  af state, lens moving, lens position, move issued, best pos
//  csr_bus   in   register index and write data
//
//  an item holds the block from its accept until its response is registered;
//  a scan start fills 14 coarse points after a reciprocal divide, a fine build
//  adds 5, and each skipped point takes a read and a check on the single
//  ram read port
//  reset is synchronous, active high; the point ram needs no clearing
//  a held response stalls the next item only at its final transfer
// ----------------------------------------------------------------------------
module contrast_af_sweep_controller_top import caf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   caf_req_if.sink   req_bus,
   caf_rsp_if.source rsp_bus,
   caf_csr_if.sink   csr_bus
);

   caf_div_cmd_type     div_cmd;
   caf_div_res_type     div_res;
   logic                ram_we;
   logic [3:0]          ram_waddr, ram_raddr;
   logic [POS_BITS-1:0] ram_wdata, ram_rdata;

   // sequencer
   caf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_bus   (csr_bus),
      .div_cmd   (div_cmd),
      .div_res   (div_res),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   // shared divider for point spacing
   caf_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   // sweep point store
   caf_ram #(.WIDTH(POS_BITS), .DEPTH(16)) u_points (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

/* sim/caf_tb_ifs.sv */
// ----------------------------------------------------------------------------
// caf testbench channel helpers
// the block's own channel interfaces are used as they are; this file only
// gives the item and result records shared by the bench
// ----------------------------------------------------------------------------
package caf_tb_pkg;
   import caf_pkg::*;

   // one input item
   typedef struct packed {
      logic [1:0]          func;
      logic [SCORE_W-1:0]  frame_score;
      logic                scene_stable;
      logic                hold_enable;
      logic [POS_BITS-1:0] hold_position;
      logic [1:0]          af_mode;
      logic [1:0]          trigger_kind;
      logic                lens_ready;
      logic                move_accepted;
   } af_item_type;

   // one result item
   typedef struct packed {
      logic [2:0]          af_state;
      logic                lens_moving;
      logic [POS_BITS-1:0] lens_position;
      logic                move_issued;
      logic [POS_BITS-1:0] best_position;
   } af_result_type;
endpackage

/* sim/contrast_af_sweep_controller_top_tb.sv */
// ----------------------------------------------------------------------------
// contrast_af_sweep_controller_top_tb
// drives frames, mode changes and triggers through the request channel with
// random idling on both sides, predicts every response with a cycle-free
// model of the focus sequencer and compares field by field
// ----------------------------------------------------------------------------
module contrast_af_sweep_controller_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import caf_pkg::*;
   import caf_tb_pkg::*;

   localparam int DRAIN_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   caf_req_if req_bus();
   caf_rsp_if rsp_bus();
   caf_csr_if csr_bus();

   contrast_af_sweep_controller_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #2 clock = ~clock;

   // register copy
   logic [9:0]  r_lens_min, r_lens_max;
   logic [3:0]  r_settle, r_rescan_frames;
   logic [5:0]  r_max_moves;
   logic [23:0] r_min_score, r_rescan_abs;
   logic [7:0]  r_rescan_rel;

   // focus state copy
   logic [1:0]  f_mode;
   bit          f_trig, f_scan, f_conv, f_fine, f_hold, f_moved;
   int unsigned f_settle, f_moves, f_changes, f_best_score, f_best_pos;
   int unsigned f_ref, f_lens, f_idx, f_moving;
   bit          f_ref_valid;
   int unsigned f_points[16];
   bit          now_ready, now_accept, now_moved;

   af_result_type expected_q[$];
   int          fail_count = 0;
   int          send_idle_pct = 0, recv_idle_pct = 0;
   bit          recv_hold = 1'b0;

   function automatic int unsigned top_pos();
      return (r_lens_max > r_lens_min) ? r_lens_max : r_lens_min;
   endfunction

   function automatic bit lens_goto(int unsigned pos);
      if (!now_ready || !now_accept) return 1'b0;
      f_lens = pos & 10'h3ff;
      now_moved = 1'b1;
      return 1'b1;
   endfunction

   function automatic void scan_begin();
      int unsigned span;
      if (!now_ready) return;
      span = top_pos() - r_lens_min;
      f_scan = 1; f_conv = 0; f_fine = 0;
      f_moves = 0; f_best_score = 0; f_best_pos = f_lens; f_changes = 0;
      for (int i = 0; i < COARSE_LEN; i++)
         f_points[i] = (r_lens_min + span * i / COARSE_DIV) & 10'h3ff;
      f_idx = 0;
      f_settle = r_settle;
   endfunction

   function automatic void scan_end();
      f_scan = 0;
      f_conv = (f_best_score >= r_min_score);
      f_changes = 0;
      f_settle = 0;
      if (f_lens != f_best_pos && lens_goto(f_best_pos)) begin
         f_moved = 1;
         f_settle = r_settle;
      end
      f_ref_valid = 0;
   endfunction

   function automatic void fine_points_build();
      int lo, hi, st, p;
      lo = r_lens_min;
      hi = top_pos();
      st = (hi - lo) / FINE_DIVISOR;
      if (st < 1) st = 1;
      for (int k = -FINE_HALF_SPAN; k <= FINE_HALF_SPAN; k++) begin
         p = int'(f_best_pos) + k * st;
         if (p < lo) p = lo;
         if (p > hi) p = hi;
         f_points[k + FINE_HALF_SPAN] = p & 10'h3ff;
      end
      f_idx = 0;
      f_fine = 1;
   endfunction

   function automatic void sweep_advance();
      int unsigned len, target;
      bit found;
      forever begin
         found = 0;
         target = 0;
         len = f_fine ? FINE_LEN : COARSE_LEN;
         while (f_idx < len) begin
            target = f_points[f_idx & 15];
            f_idx++;
            if (target != f_lens) begin
               found = 1;
               break;
            end
         end
         if (found) begin
            if (f_moves >= r_max_moves) begin
               scan_end();
               return;
            end
            f_moves++;
            if (!lens_goto(target)) begin
               scan_end();
               return;
            end
            f_settle = r_settle;
            f_moved = 1;
            return;
         end
         if (f_fine) begin
            scan_end();
            return;
         end
         fine_points_build();
      end
   endfunction

   function automatic void frame_apply(af_item_type it);
      longint unsigned delta;
      f_moving = f_moved;
      f_moved = 0;
      if (!now_ready) return;
      if (it.hold_enable && it.hold_position >= r_lens_min &&
          it.hold_position <= top_pos()) begin
         f_hold = 1;
         f_scan = 0;
         if (f_lens != it.hold_position) begin
            if (lens_goto(it.hold_position)) begin
               f_moved = 1;
               f_settle = r_settle;
            end
            return;
         end
         if (f_settle > 0) f_settle--;
         return;
      end
      if (f_hold) begin
         f_hold = 0;
         if (f_mode >= 2) scan_begin();
      end
      if (f_mode == MODE_OFF) return;
      if (f_mode == MODE_AUTO && !f_trig) begin
         f_scan = 0;
         return;
      end
      if (!it.scene_stable) return;
      if (!f_scan) begin
         if (f_trig) return;
         if (f_settle > 0) begin
            f_settle--;
            return;
         end
         if (!f_ref_valid) begin
            f_ref = it.frame_score;
            f_ref_valid = 1;
            f_changes = 0;
            return;
         end
         delta = (it.frame_score > f_ref) ? it.frame_score - f_ref : f_ref - it.frame_score;
         if (delta * 256 > longint'(f_ref) * r_rescan_rel && delta > r_rescan_abs) begin
            if (f_changes < 15) f_changes++;
            if (f_changes >= r_rescan_frames) scan_begin();
         end else begin
            f_changes = 0;
         end
         return;
      end
      if (f_settle > 0) begin
         f_settle--;
         return;
      end
      if (it.frame_score > f_best_score) begin
         f_best_score = it.frame_score;
         f_best_pos = f_lens;
      end
      sweep_advance();
   endfunction

   function automatic logic [2:0] state_report();
      if (!now_ready || f_mode == MODE_OFF || f_hold) return AF_INACTIVE;
      if (f_mode == MODE_AUTO) begin
         if (!f_trig) return AF_INACTIVE;
         if (f_scan) return AF_ACTIVE_SCAN;
         return f_conv ? AF_FOCUSED_LOCK : AF_UNFOCUSED_LOCK;
      end
      if (f_scan) return AF_PASSIVE_SCAN;
      if (f_trig) return f_conv ? AF_FOCUSED_LOCK : AF_UNFOCUSED_LOCK;
      return f_conv ? AF_PASSIVE_FOCUS : AF_PASSIVE_UNFOC;
   endfunction

   // predicted response for one accepted item
   function automatic af_result_type focus_predict(af_item_type it);
      af_result_type r;
      now_ready = it.lens_ready;
      now_accept = it.move_accepted;
      now_moved = 0;
      case (it.func)
         FUNC_FRAME: frame_apply(it);
         FUNC_MODE: begin
            if (it.af_mode != f_mode) begin
               f_mode = it.af_mode;
               f_trig = 0; f_scan = 0; f_conv = 0;
               f_changes = 0;
               f_ref_valid = 0;
               if (f_mode >= 2) scan_begin();
            end
         end
         FUNC_TRIG: begin
            if (f_mode != MODE_OFF) begin
               if (it.trigger_kind == TRIG_START) begin
                  f_trig = 1;
                  if (f_mode == MODE_AUTO) scan_begin();
                  else if (f_scan && f_mode == MODE_VIDEO) scan_end();
               end else if (it.trigger_kind == TRIG_CANCEL) begin
                  f_trig = 0;
                  f_changes = 0;
                  if (f_mode == MODE_AUTO) begin
                     f_scan = 0;
                     f_conv = 0;
                  end
               end
            end
         end
         default: ;
      endcase
      r.af_state = state_report();
      r.lens_moving = f_moving[0];
      r.lens_position = f_lens[9:0];
      r.move_issued = now_moved;
      r.best_position = f_best_pos[9:0];
      return r;
   endfunction

   function automatic void focus_reset();
      r_lens_min = 0; r_lens_max = 1023; r_settle = 3; r_max_moves = 24;
      r_min_score = 160; r_rescan_rel = 77; r_rescan_abs = 80; r_rescan_frames = 3;
      f_mode = MODE_OFF;
      {f_trig, f_scan, f_conv, f_fine, f_hold, f_moved} = '0;
      f_settle = 0; f_moves = 0; f_changes = 0; f_best_score = 0; f_best_pos = 0;
      f_ref = 0; f_ref_valid = 0; f_lens = 0; f_idx = 0; f_moving = 0;
      foreach (f_points[i]) f_points[i] = 0;
   endfunction

   // register write, block idle
   task automatic csr_write(logic [2:0] addr, logic [23:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= addr;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (addr)
         CSR_LENS_MIN:      r_lens_min = data[9:0];
         CSR_LENS_MAX:      r_lens_max = data[9:0];
         CSR_SETTLE_FRAMES: r_settle = data[3:0];
         CSR_MAX_MOVES:     r_max_moves = data[5:0];
         CSR_MIN_SCORE:     r_min_score = data;
         CSR_RESCAN_REL:    r_rescan_rel = data[7:0];
         CSR_RESCAN_ABS:    r_rescan_abs = data;
         default:           r_rescan_frames = data[3:0];
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one transfer on the request channel; expected stored at acceptance
   task automatic item_send(af_item_type it, bit check_direct = 0,
                            af_result_type direct = '0);
      af_result_type p;
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(negedge clock);
      req_bus.valid         <= 1'b1;
      req_bus.func          <= it.func;
      req_bus.frame_score   <= it.frame_score;
      req_bus.scene_stable  <= it.scene_stable;
      req_bus.hold_enable   <= it.hold_enable;
      req_bus.hold_position <= it.hold_position;
      req_bus.af_mode       <= it.af_mode;
      req_bus.trigger_kind  <= it.trigger_kind;
      req_bus.lens_ready    <= it.lens_ready;
      req_bus.move_accepted <= it.move_accepted;
      do @(posedge clock); while (!req_bus.ready);
      p = focus_predict(it);
      if (check_direct && p != direct) begin
         $error("directed row disagrees with predictor: %h vs %h", direct, p);
         fail_count++;
      end
      expected_q.insert(expected_q.size(), p);
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   function automatic af_item_type item_make(logic [1:0] func, logic [23:0] score,
                                             logic stable, logic hold, logic [9:0] hpos,
                                             logic [1:0] mode, logic [1:0] trig,
                                             logic rdy, logic acc);
      af_item_type it;
      it.func = func; it.frame_score = score; it.scene_stable = stable;
      it.hold_enable = hold; it.hold_position = hpos; it.af_mode = mode;
      it.trigger_kind = trig; it.lens_ready = rdy; it.move_accepted = acc;
      return it;
   endfunction

   // random frame, mostly well formed
   function automatic af_item_type frame_random(int unsigned peak);
      af_item_type it;
      int unsigned d;
      it = item_make(FUNC_FRAME, 0, 1, 0, $urandom, $urandom, $urandom, 1, 1);
      d = (f_lens > peak) ? f_lens - peak : peak - f_lens;
      it.frame_score = (d > 1000) ? $urandom_range(15) : (1000 - d) * 16 + $urandom_range(15);
      if ($urandom_range(99) < 3) it.frame_score = $urandom;
      if ($urandom_range(99) < 6) it.scene_stable = 0;
      if ($urandom_range(99) < 4) it.hold_enable = 1;
      if ($urandom_range(99) < 3) it.lens_ready = 0;
      if ($urandom_range(99) < 4) it.move_accepted = 0;
      return it;
   endfunction

   task automatic random_block(int count);
      af_item_type it;
      int unsigned peak;
      peak = $urandom_range(1023);
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(99)) inside
            [0:3]: it = item_make(FUNC_MODE, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom_range(99) < 90, $urandom);
            [4:8]: it = item_make(FUNC_TRIG, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom_range(99) < 90, $urandom);
            9: it = item_make(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom);
            10: begin
               peak = $urandom_range(1023);
               it = frame_random(peak);
            end
            default: it = frame_random(peak);
         endcase
         if (it.func == FUNC_MODE && f_mode == MODE_AUTO && $urandom_range(1))
            it.func = FUNC_TRIG;
         item_send(it);
      end
   endtask

   typedef struct {
      af_item_type   it;
      bit            known;
      af_result_type res;
   } stim_row_type;

   // directed table
   stim_row_type directed[$];

   task automatic directed_run();
      af_result_type z;
      z = '0;
      directed = '{
         '{item_make(FUNC_FRAME, 24'hffffff, 1, 0, 0, MODE_OFF, 0, 1, 1), 1, z},
         '{item_make(2'd3, 0, 0, 0, 0, MODE_AUTO, 0, 1, 1), 1, z},
         '{item_make(FUNC_TRIG, 0, 0, 0, 0, 0, TRIG_START, 1, 1), 1, z},
         '{item_make(FUNC_FRAME, 0, 1, 1, 10'h3ff, 0, 0, 0, 1), 0, z},
         '{item_make(FUNC_MODE, 0, 0, 0, 0, MODE_AUTO, 0, 1, 1), 0, z},
         '{item_make(FUNC_TRIG, 0, 0, 0, 0, 0, 2'd0, 1, 1), 0, z},
         '{item_make(FUNC_TRIG, 0, 0, 0, 0, 0, 2'd3, 1, 1), 0, z},
         '{item_make(FUNC_TRIG, 0, 0, 0, 0, 0, TRIG_START, 0, 1), 0, z},
         '{item_make(FUNC_TRIG, 0, 0, 0, 0, 0, TRIG_START, 1, 1), 0, z},
         '{item_make(FUNC_FRAME, 24'h100, 1, 0, 0, 0, 0, 1, 1), 0, z},
         '{item_make(FUNC_FRAME, 24'h100, 0, 0, 0, 0, 0, 1, 1), 0, z},
         '{item_make(FUNC_FRAME, 24'hffffff, 1, 0, 0, 0, 0, 1, 1), 0, z},
         '{item_make(FUNC_FRAME, 24'h0, 1, 0, 0, 0, 0, 1, 0), 0, z},
         '{item_make(FUNC_FRAME, 24'h0, 1, 0, 0, 0, 0, 1, 1), 0, z},
         '{item_make(FUNC_FRAME, 24'h0, 1, 1, 10'd500, 0, 0, 1, 1), 0, z},
         '{item_make(FUNC_FRAME, 24'h0, 1, 1, 10'd500, 0, 0, 1, 1), 0, z},
         '{item_make(FUNC_MODE, 0, 0, 0, 0, 2'd2, 0, 1, 1), 0, z},
         '{item_make(FUNC_FRAME, 24'h10, 1, 0, 0, 0, 0, 1, 1), 0, z},
         '{item_make(FUNC_MODE, 0, 0, 0, 0, MODE_VIDEO, 0, 1, 1), 0, z},
         '{item_make(FUNC_TRIG, 0, 0, 0, 0, 0, TRIG_START, 1, 1), 0, z},
         '{item_make(FUNC_TRIG, 0, 0, 0, 0, 0, TRIG_CANCEL, 1, 1), 0, z},
         '{item_make(FUNC_MODE, 0, 0, 0, 0, MODE_OFF, 0, 1, 1), 0, z}
      };
      foreach (directed[i]) item_send(directed[i].it, directed[i].known, directed[i].res);
   endtask

   // response check
   always @(posedge clock) begin
      af_result_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.af_state, rsp_bus.lens_moving, rsp_bus.lens_position,
                rsp_bus.move_issued, rsp_bus.best_position};
         if (expected_q.size() == 0) begin
            $error("response with nothing expected: %h", got);
            fail_count++;
         end else begin
            want = expected_q.pop_front();
            if (got.af_state != want.af_state) begin
               $error("af_state expected %0d got %0d", want.af_state, got.af_state);
               fail_count++;
            end
            if (got.lens_moving != want.lens_moving) begin
               $error("lens_moving expected %0d got %0d", want.lens_moving,
                      got.lens_moving);
               fail_count++;
            end
            if (got.lens_position != want.lens_position) begin
               $error("lens_position expected %0d got %0d", want.lens_position,
                      got.lens_position);
               fail_count++;
            end
            if (got.move_issued != want.move_issued) begin
               $error("move_issued expected %0d got %0d", want.move_issued,
                      got.move_issued);
               fail_count++;
            end
            if (got.best_position != want.best_position) begin
               $error("best_position expected %0d got %0d", want.best_position,
                      got.best_position);
               fail_count++;
            end
         end
      end
   end

   // receiver ready with random stalls and one long hold-off
   always @(negedge clock) begin
      if (recv_hold)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      req_bus.valid = 0; req_bus.func = 0; req_bus.frame_score = 0;
      req_bus.scene_stable = 0; req_bus.hold_enable = 0; req_bus.hold_position = 0;
      req_bus.af_mode = 0; req_bus.trigger_kind = 0; req_bus.lens_ready = 0;
      req_bus.move_accepted = 0;
      csr_bus.valid = 0; csr_bus.addr = 0; csr_bus.data = 0;
      focus_reset();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_run();
      wait_drained();

      // phase 1: sender idles rarely, receiver often; extreme range settings
      send_idle_pct = 9; recv_idle_pct = 52;
      csr_write(CSR_SETTLE_FRAMES, 0);
      csr_write(CSR_MAX_MOVES, 63);
      csr_write(CSR_MIN_SCORE, 24'hffffff);
      random_block(250);
      wait_drained();
      csr_write(CSR_LENS_MIN, 10'd1023);
      csr_write(CSR_LENS_MAX, 10'd0);
      csr_write(CSR_MIN_SCORE, 0);
      csr_write(CSR_RESCAN_REL, 0);
      csr_write(CSR_RESCAN_ABS, 0);
      csr_write(CSR_RESCAN_FRAMES, 1);
      random_block(150);
      wait_drained();

      // long receiver hold-off while items keep coming
      fork
         begin
            recv_hold = 1;
            repeat (300) @(posedge clock);
            recv_hold = 0;
         end
         random_block(40);
      join
      wait_drained();

      // phase 2: sender idles often, receiver rarely
      send_idle_pct = 52; recv_idle_pct = 9;
      csr_write(CSR_LENS_MIN, 10'd100);
      csr_write(CSR_LENS_MAX, 10'd900);
      csr_write(CSR_SETTLE_FRAMES, 15);
      csr_write(CSR_MAX_MOVES, 1);
      csr_write(CSR_RESCAN_REL, 255);
      csr_write(CSR_RESCAN_ABS, 24'hffffff);
      csr_write(CSR_RESCAN_FRAMES, 15);
      random_block(300);
      wait_drained();
      csr_write(CSR_LENS_MIN, 10'd0);
      csr_write(CSR_LENS_MAX, 10'd1023);
      csr_write(CSR_SETTLE_FRAMES, 1);
      csr_write(CSR_MAX_MOVES, 24);
      csr_write(CSR_MIN_SCORE, 160);
      csr_write(CSR_RESCAN_REL, 77);
      csr_write(CSR_RESCAN_ABS, 80);
      csr_write(CSR_RESCAN_FRAMES, 2);
      random_block(600);
      wait_drained();

      // phase 3: no idling
      send_idle_pct = 0; recv_idle_pct = 0;
      csr_write(CSR_LENS_MIN, 10'd500);
      csr_write(CSR_LENS_MAX, 10'd520);
      csr_write(CSR_SETTLE_FRAMES, 2);
      random_block(300);
      wait_drained();
      csr_write(CSR_LENS_MIN, 10'd3);
      csr_write(CSR_LENS_MAX, 10'd1000);
      csr_write(CSR_MAX_MOVES, 40);
      random_block(300);
      wait_drained();

      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/caf_pkg.sv
hw/rtl/caf_ifs.sv
hw/rtl/caf_ram.sv
hw/rtl/caf_div.sv
hw/rtl/caf_ctrl.sv
hw/rtl/contrast_af_sweep_controller_top.sv
sim/caf_tb_ifs.sv
sim/contrast_af_sweep_controller_top_tb.sv
